FILE: rtl/fenwick_range_sum_unit_defines.svh
// ---------------------------------------------------------------------------
// fenwick range sum unit assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef FENWICK_RANGE_SUM_UNIT_DEFINES_SVH
`define FENWICK_RANGE_SUM_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frs assertion failed");
// next-cycle implication
`define FRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frs assertion failed");
`else
`define FRS_ASSERT_IMP(label, ante, cons)
`define FRS_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/frs_pkg.sv
// ---------------------------------------------------------------------------
// frs_pkg
// Widths, defaults and request codes of the fenwick range sum unit.
// ---------------------------------------------------------------------------
package frs_pkg;

  // payload widths
  localparam int DATA_W  = 64;
  localparam int POS_W   = 10;
  localparam int BOUND_W = 11;
  localparam int SIZE_W  = 11;

  // default storage size and size register reset value
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int SIZE_RESET        = 1024;

  // request codes
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUM = 1'b1;

endpackage

FILE: rtl/fenwick_range_sum_unit.sv
// ---------------------------------------------------------------------------
// fenwick_range_sum_unit
// Binary indexed tree of 64-bit counters with point add and range sum.
// ---------------------------------------------------------------------------
// The tree cells live in one synchronous memory of MAX_POSITIONS+1 words
// with one read and one write port. An add beat walks upward from
// position+1, writing each cell back with delta added while the next
// cell is read; a sum beat walks the prefix of range_right and then the
// prefix of range_left, one memory read per cycle. One beat is worked on
// at a time. After reset and after every write of the size register all
// MAX_POSITIONS+1 words of the memory are swept to zero, one word per
// cycle, while in_stall is high.
// A finished sum sits in the output register, so add beats keep flowing
// while it waits.
`include "fenwick_range_sum_unit_defines.svh"

module fenwick_range_sum_unit
  import frs_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // size register write
  input  logic                     cfg_wr_en,
  input  logic [SIZE_W-1:0]        cfg_wr_data,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] delta,
  input  logic [BOUND_W-1:0]       range_left,
  input  logic [BOUND_W-1:0]       range_right,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] range_sum
);

  localparam int DEPTH  = MAX_POSITIONS + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WALK_W = IDX_W + 1;
  localparam int CW     = (WALK_W > BOUND_W) ? WALK_W : BOUND_W;
  localparam int RESET_N = (SIZE_RESET > MAX_POSITIONS) ? MAX_POSITIONS : SIZE_RESET;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POSITIONS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    n;
  logic [IDX_W-1:0]    clr_addr;
  logic [CW-1:0]       walk;
  logic [IDX_W-1:0]    left_hold;
  logic                phase;
  logic                pend;
  logic                pend_neg;
  logic [IDX_W-1:0]    upd_addr;
  logic [DATA_W-1:0]   delta_hold;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   mem_q;

  logic [DATA_W-1:0]   mem [0:DEPTH-1];

  logic [CW-1:0]       n_ext;
  logic [CW-1:0]       right_ext;
  logic [CW-1:0]       left_ext;
  logic [CW-1:0]       cfg_ext;
  logic [IDX_W-1:0]    right_cl;
  logic [IDX_W-1:0]    left_cl;
  logic [IDX_W-1:0]    cfg_n;
  logic                in_take;
  logic                out_free;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                q_done;

  // bound clamping and size saturation
  always_comb begin
    n_ext     = CW'(n);
    right_ext = CW'(range_right);
    left_ext  = CW'(range_left);
    cfg_ext   = CW'(cfg_wr_data);
    right_cl  = (right_ext > n_ext) ? n : right_ext[IDX_W-1:0];
    left_cl   = (left_ext > n_ext) ? n : left_ext[IDX_W-1:0];
    cfg_n     = (cfg_ext > CW'(MAX_POSITIONS)) ? LAST_IDX : cfg_ext[IDX_W-1:0];
  end

  // handshakes
  assign in_stall = (state != ST_IDLE) || cfg_wr_en;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign q_done   = (state == ST_QRY) && (walk == '0) && phase && !pend && out_free;

  // memory port control
  always_comb begin
    rd_en   = ((state == ST_UPD) && (walk <= n_ext)) ||
              ((state == ST_QRY) && (walk != '0));
    rd_addr = walk[IDX_W-1:0];
    wr_en   = (state == ST_CLEAR) || ((state == ST_UPD) && pend);
    wr_addr = (state == ST_CLEAR) ? clr_addr : upd_addr;
    wr_data = (state == ST_CLEAR) ? '0 : (mem_q + delta_hold);
  end

  // tree cell memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      n         <= IDX_W'(RESET_N);
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend     <= rd_en && !cfg_wr_en;
      pend_neg <= phase;

      // result register loads a finished sum, else drains on a taken beat
      if (q_done && !cfg_wr_en) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        // new size: rebuild an empty tree
        n        <= cfg_n;
        clr_addr <= '0;
        state    <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + IDX_W'(1);
            if (clr_addr == LAST_IDX) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_take) begin
              delta_hold <= delta;
              acc        <= '0;
              phase      <= 1'b0;
              left_hold  <= left_cl;
              if (req_type == REQ_ADD) begin
                walk  <= CW'(position) + CW'(1);
                state <= ST_UPD;
              end else begin
                walk  <= CW'(right_cl);
                state <= ST_QRY;
              end
            end
          end
          ST_UPD: begin
            // read ahead while the previous cell is written back
            if (rd_en) begin
              upd_addr <= walk[IDX_W-1:0];
              walk     <= walk + (walk & (~walk + CW'(1)));
            end else if (!pend) begin
              state <= ST_IDLE;
            end
          end
          ST_QRY: begin
            if (pend) begin
              acc <= pend_neg ? (acc - mem_q) : (acc + mem_q);
            end
            if (walk != '0) begin
              walk <= walk & (walk - CW'(1));
            end else if (!phase) begin
              phase <= 1'b1;
              walk  <= CW'(left_hold);
            end else if (q_done) begin
              range_sum <= acc;
              state     <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // checks
  `FRS_ASSERT_IMP(a_upd_wr_in_range,
    wr_en && (state != ST_CLEAR), (wr_addr != '0) && (CW'(wr_addr) <= n_ext))
  `FRS_ASSERT_IMP(a_rd_in_range, rd_en, (rd_addr != '0) && (CW'(rd_addr) <= n_ext))
  `FRS_ASSERT_IMP(a_pend_follows_read, pend, $past(rd_en))
  `FRS_ASSERT_NXT(a_sum_loaded, q_done && !cfg_wr_en,
    out_valid && (range_sum == $past(acc)))

endmodule
